[rtl/core/ppr_pkg.sv]
// ----------------------------------------------------------------------------
// ppr_pkg
// shared types and constants of the projective point and rectangle mapper
// ----------------------------------------------------------------------------
package ppr_pkg;

    localparam int COORD_W   = 32;
    localparam int QUO_W     = 32;
    localparam int CFG_W     = 64;
    localparam int CFG_IDX_W = 4;

    // stage counts of the sub-blocks
    localparam int PROJ_LAT = 2;
    localparam int DIV_LAT  = QUO_W + 2;
    localparam int BOX_LAT  = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_R11  = 4'd0,
        CFG_R12  = 4'd1,
        CFG_R13  = 4'd2,
        CFG_R21  = 4'd3,
        CFG_R22  = 4'd4,
        CFG_R23  = 4'd5,
        CFG_PERSP = 4'd6,
        CFG_R33  = 4'd7
    } t_cfg_reg;

    typedef enum logic {
        OP_POINT = 1'b0,
        OP_RECT  = 1'b1
    } t_opcode;

    typedef struct packed {
        t_opcode                    opcode;
        logic signed [COORD_W-1:0]  x_coord;
        logic signed [COORD_W-1:0]  y_coord;
        logic signed [COORD_W-1:0]  rect_width;
        logic signed [COORD_W-1:0]  rect_height;
    } t_in_item;

    typedef struct packed {
        logic signed [COORD_W-1:0]  out_x;
        logic signed [COORD_W-1:0]  out_y;
        logic signed [COORD_W-1:0]  out_width;
        logic signed [COORD_W-1:0]  out_height;
    } t_out_item;

    typedef struct packed {
        logic signed [COORD_W-1:0] r11;
        logic signed [COORD_W-1:0] r12;
        logic signed [COORD_W-1:0] r13;
        logic signed [COORD_W-1:0] r21;
        logic signed [COORD_W-1:0] r22;
        logic signed [COORD_W-1:0] r23;
        logic signed [COORD_W-1:0] r31;
        logic signed [COORD_W-1:0] r32;
        logic signed [COORD_W-1:0] r33;
    } t_matrix;

    typedef struct packed {
        t_opcode opcode;
        logic    empty;
    } t_box_ctl;

    localparam logic signed [COORD_W-1:0] S32_MAX = 32'sh7fff_ffff;
    localparam logic signed [COORD_W-1:0] S32_MIN = 32'sh8000_0000;

endpackage

[rtl/core/ppr_proj.sv]
// ----------------------------------------------------------------------------
// ppr_proj
// one corner through the matrix: products, then floor shift and row sums
// ----------------------------------------------------------------------------
module ppr_proj #(
    parameter int FRAC_BITS = 16,
    parameter int SW        = 66 - FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  ppr_pkg::t_matrix                     i_mat,
    input  logic signed [ppr_pkg::COORD_W-1:0]   i_x,
    input  logic signed [ppr_pkg::COORD_W-1:0]   i_y,
    output logic signed [SW-1:0]                 o_tx,
    output logic signed [SW-1:0]                 o_ty,
    output logic signed [SW-1:0]                 o_w
);

    localparam int PW = 2 * ppr_pkg::COORD_W;

    logic signed [PW-1:0] r_p [6];
    logic signed [PW-1:0] n_p [6];
    logic signed [ppr_pkg::COORD_W-1:0] r_r13, r_r23, r_r33;

    always_comb begin
        n_p[0] = i_mat.r11 * i_x;
        n_p[1] = i_mat.r12 * i_y;
        n_p[2] = i_mat.r21 * i_x;
        n_p[3] = i_mat.r22 * i_y;
        n_p[4] = i_mat.r31 * i_x;
        n_p[5] = i_mat.r32 * i_y;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p   <= n_p;
            r_r13 <= i_mat.r13;
            r_r23 <= i_mat.r23;
            r_r33 <= i_mat.r33;
        end
    end

    // arithmetic shift of the product is the floor
    function automatic logic signed [SW-1:0] fl(input logic signed [PW-1:0] p);
        logic signed [PW-FRAC_BITS-1:0] s;
        s = $signed(p[PW-1:FRAC_BITS]);
        return SW'(s);
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_tx <= fl(r_p[0]) + fl(r_p[1]) + SW'(r_r13);
            o_ty <= fl(r_p[2]) + fl(r_p[3]) + SW'(r_r23);
            o_w  <= fl(r_p[4]) + fl(r_p[5]) + SW'(r_r33);
        end
    end

endmodule

[rtl/core/ppr_div.sv]
// ----------------------------------------------------------------------------
// ppr_div
// pipelined restoring divider, one quotient bit per stage, with saturation
// ----------------------------------------------------------------------------
module ppr_div #(
    parameter int FRAC_BITS = 16,
    parameter int SW        = 66 - FRAC_BITS
) (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  logic signed [SW-1:0]                 i_num,
    input  logic signed [SW-1:0]                 i_den,
    output logic signed [ppr_pkg::COORD_W-1:0]   o_quo
);

    localparam int QW   = ppr_pkg::QUO_W;
    localparam int IB   = QW - FRAC_BITS;
    localparam int CW   = SW + IB;

    typedef struct packed {
        logic neg;
        logic ovf;
        logic byp;
    } t_div_ctl;

    logic [SW-1:0]                        r_rem  [QW+1];
    logic [SW-1:0]                        r_ud   [QW+1];
    logic [QW-1:0]                        r_lq   [QW+1];
    t_div_ctl                             r_ctl  [QW+1];
    logic signed [ppr_pkg::COORD_W-1:0]   r_satn [QW+1];

    // entry stage: magnitudes, sign, integer overflow, bypass
    logic [SW-1:0] un, ud;
    logic          byp;
    logic signed [ppr_pkg::COORD_W-1:0] satn;

    always_comb begin
        un   = i_num[SW-1] ? SW'(-i_num) : SW'(i_num);
        ud   = i_den[SW-1] ? SW'(-i_den) : SW'(i_den);
        byp  = (i_den == '0) || (i_den == SW'(64'd1 << FRAC_BITS));
        if (i_num[SW-1:ppr_pkg::COORD_W-1] == '0 || i_num[SW-1:ppr_pkg::COORD_W-1] == '1) begin
            satn = i_num[ppr_pkg::COORD_W-1:0];
        end else begin
            satn = i_num[SW-1] ? ppr_pkg::S32_MIN : ppr_pkg::S32_MAX;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]     <= un >> IB;
            r_ud[0]      <= ud;
            r_lq[0]      <= {un[IB-1:0], FRAC_BITS'(0)};
            r_ctl[0].neg <= i_num[SW-1] ^ i_den[SW-1];
            r_ctl[0].ovf <= CW'(un) >= (CW'(ud) << IB);
            r_ctl[0].byp <= byp;
            r_satn[0]    <= satn;
        end
    end

    for (genvar k = 0; k < QW; k++) begin : g_step
        logic [SW:0]   t;
        logic          qb;
        logic [SW-1:0] n_rem;

        always_comb begin
            t     = {r_rem[k], r_lq[k][QW-1]};
            qb    = t >= {1'b0, r_ud[k]};
            n_rem = qb ? SW'(t - {1'b0, r_ud[k]}) : SW'(t);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k+1]  <= n_rem;
                r_ud[k+1]   <= r_ud[k];
                r_lq[k+1]   <= {r_lq[k][QW-2:0], qb};
                r_ctl[k+1]  <= r_ctl[k];
                r_satn[k+1] <= r_satn[k];
            end
        end
    end

    // sign and range of the quotient
    logic [QW-1:0] q;
    logic signed [ppr_pkg::COORD_W-1:0] n_quo;

    always_comb begin
        q = r_lq[QW];
        if (r_ctl[QW].byp) begin
            n_quo = r_satn[QW];
        end else if (r_ctl[QW].ovf) begin
            n_quo = r_ctl[QW].neg ? ppr_pkg::S32_MIN : ppr_pkg::S32_MAX;
        end else if (r_ctl[QW].neg) begin
            n_quo = (q[QW-1] && (q[QW-2:0] != '0)) ? ppr_pkg::S32_MIN : $signed(-q);
        end else begin
            n_quo = q[QW-1] ? ppr_pkg::S32_MAX : $signed(q);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_quo <= n_quo;
        end
    end

endmodule

[rtl/core/ppr_box.sv]
// ----------------------------------------------------------------------------
// ppr_box
// bounding box of four mapped corners, point and empty cases
// ----------------------------------------------------------------------------
module ppr_box (
    input  logic                                 i_clk,
    input  logic                                 i_en,
    input  ppr_pkg::t_box_ctl                    i_ctl,
    input  logic signed [ppr_pkg::COORD_W-1:0]   i_xs [4],
    input  logic signed [ppr_pkg::COORD_W-1:0]   i_ys [4],
    output ppr_pkg::t_out_item                   o_item
);

    localparam int CW = ppr_pkg::COORD_W;

    logic signed [CW-1:0] r_minx, r_maxx, r_miny, r_maxy, r_x0, r_y0;
    ppr_pkg::t_box_ctl    r_ctl;

    function automatic logic signed [CW-1:0] mn(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic signed [CW-1:0] mx(input logic signed [CW-1:0] a,
                                                input logic signed [CW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_minx <= mn(mn(i_xs[0], i_xs[1]), mn(i_xs[2], i_xs[3]));
            r_maxx <= mx(mx(i_xs[0], i_xs[1]), mx(i_xs[2], i_xs[3]));
            r_miny <= mn(mn(i_ys[0], i_ys[1]), mn(i_ys[2], i_ys[3]));
            r_maxy <= mx(mx(i_ys[0], i_ys[1]), mx(i_ys[2], i_ys[3]));
            r_x0   <= i_xs[0];
            r_y0   <= i_ys[0];
            r_ctl  <= i_ctl;
        end
    end

    logic [CW:0] dx, dy;
    ppr_pkg::t_out_item n_item;

    always_comb begin
        dx = {r_maxx[CW-1], r_maxx} - {r_minx[CW-1], r_minx};
        dy = {r_maxy[CW-1], r_maxy} - {r_miny[CW-1], r_miny};
        n_item = '0;
        if (r_ctl.opcode == ppr_pkg::OP_POINT) begin
            n_item.out_x = r_x0;
            n_item.out_y = r_y0;
        end else if (!r_ctl.empty) begin
            n_item.out_x      = r_minx;
            n_item.out_y      = r_miny;
            n_item.out_width  = (dx[CW:CW-1] != 2'b00) ? ppr_pkg::S32_MAX : $signed(dx[CW-1:0]);
            n_item.out_height = (dy[CW:CW-1] != 2'b00) ? ppr_pkg::S32_MAX : $signed(dy[CW-1:0]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_item <= n_item;
        end
    end

endmodule

[rtl/core/projective_point_rect_map_core.sv]
// ----------------------------------------------------------------------------
// projective_point_rect_map_core
// maps points and rectangles through a 3x3 homogeneous Q matrix
// ----------------------------------------------------------------------------
// usage
//   input channel: i_valid / o_stall carry one t_in_item per transfer; opcode
//   selects a point or a rectangle. output channel: o_valid / i_stall carry
//   one t_out_item per transfer, exactly one result for every input transfer,
//   in order.
//   matrix registers are written through i_cfg_we / i_cfg_idx / i_cfg_data
//   while the block holds no items; writes beyond index 7 are dropped.
// pipeline and throughput
//   an item passes one corner stage, two multiply and sum stages, 34 divider
//   stages (entry, one quotient bit per step stage, output) and two bounding
//   box stages. one item per cycle is accepted while the output is not held;
//   the cost is four corner units and eight divider pipelines side by side.
// reset
//   synchronous active-low reset clears all valid bits and loads the
//   identity matrix; payload registers are not reset.
// stall
//   the whole pipeline freezes while o_valid is high and i_stall is high;
//   o_stall is raised in that case so no transfer is lost or repeated.
// ----------------------------------------------------------------------------
module projective_point_rect_map_core #(
    parameter int FRAC_BITS = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // input channel
    input  logic                                i_valid,
    output logic                                o_stall,
    input  ppr_pkg::t_in_item                   i_item,
    // output channel
    output logic                                o_valid,
    input  logic                                i_stall,
    output ppr_pkg::t_out_item                  o_item,
    // configuration writes
    input  logic                                i_cfg_we,
    input  logic [ppr_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [ppr_pkg::CFG_W-1:0]           i_cfg_data
);

    localparam int CW  = ppr_pkg::COORD_W;
    // width of the row sums: floor-shifted product plus headroom for two adds
    localparam int SW  = 66 - FRAC_BITS;
    localparam int LAT = 1 + ppr_pkg::PROJ_LAT + ppr_pkg::DIV_LAT + ppr_pkg::BOX_LAT;
    localparam int CTL_DLY = ppr_pkg::PROJ_LAT + ppr_pkg::DIV_LAT;
    localparam logic signed [CW-1:0] ONE = CW'(64'd1 << FRAC_BITS);

    // ------------------------------------------------------------------
    // matrix registers
    // ------------------------------------------------------------------
    ppr_pkg::t_matrix r_mat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mat     <= '0;
            r_mat.r11 <= ONE;
            r_mat.r22 <= ONE;
            r_mat.r33 <= ONE;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                ppr_pkg::CFG_R11: begin
                    r_mat.r11 <= i_cfg_data[CW-1:0];
                end
                ppr_pkg::CFG_R12: begin
                    r_mat.r12 <= i_cfg_data[CW-1:0];
                end
                ppr_pkg::CFG_R13: begin
                    r_mat.r13 <= i_cfg_data[CW-1:0];
                end
                ppr_pkg::CFG_R21: begin
                    r_mat.r21 <= i_cfg_data[CW-1:0];
                end
                ppr_pkg::CFG_R22: begin
                    r_mat.r22 <= i_cfg_data[CW-1:0];
                end
                ppr_pkg::CFG_R23: begin
                    r_mat.r23 <= i_cfg_data[CW-1:0];
                end
                ppr_pkg::CFG_PERSP: begin
                    r_mat.r31 <= i_cfg_data[CW-1:0];
                    r_mat.r32 <= i_cfg_data[2*CW-1:CW];
                end
                ppr_pkg::CFG_R33: begin
                    r_mat.r33 <= i_cfg_data[CW-1:0];
                end
                default: begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // global advance: everything moves unless the output is held
    // ------------------------------------------------------------------
    logic       en;
    logic [LAT-1:0] r_vld;

    assign en      = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // corner stage: far edges saturate before mapping
    // ------------------------------------------------------------------
    logic [CW:0]          sx, sy;
    logic signed [CW-1:0] n_x2, n_y2;
    logic signed [CW-1:0] r_x, r_y, r_x2, r_y2;
    ppr_pkg::t_box_ctl    n_ctl;
    ppr_pkg::t_box_ctl    r_ctl [CTL_DLY+1];

    always_comb begin
        sx = {i_item.x_coord[CW-1], i_item.x_coord}
           + {i_item.rect_width[CW-1], i_item.rect_width};
        sy = {i_item.y_coord[CW-1], i_item.y_coord}
           + {i_item.rect_height[CW-1], i_item.rect_height};
        n_x2 = (sx[CW] != sx[CW-1]) ? (sx[CW] ? ppr_pkg::S32_MIN : ppr_pkg::S32_MAX)
                                    : $signed(sx[CW-1:0]);
        n_y2 = (sy[CW] != sy[CW-1]) ? (sy[CW] ? ppr_pkg::S32_MIN : ppr_pkg::S32_MAX)
                                    : $signed(sy[CW-1:0]);
        n_ctl.opcode = i_item.opcode;
        n_ctl.empty  = i_item.rect_width[CW-1] || (i_item.rect_width == '0)
                    || i_item.rect_height[CW-1] || (i_item.rect_height == '0);
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x      <= i_item.x_coord;
            r_y      <= i_item.y_coord;
            r_x2     <= n_x2;
            r_y2     <= n_y2;
            r_ctl[0] <= n_ctl;
            for (int i = 0; i < CTL_DLY; i++) begin
                r_ctl[i+1] <= r_ctl[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // four corners: projection then division of tx and ty by w
    // ------------------------------------------------------------------
    logic signed [CW-1:0] cx [4];
    logic signed [CW-1:0] cy [4];
    logic signed [CW-1:0] mx [4];
    logic signed [CW-1:0] my [4];

    assign cx[0] = r_x;   assign cy[0] = r_y;
    assign cx[1] = r_x2;  assign cy[1] = r_y;
    assign cx[2] = r_x;   assign cy[2] = r_y2;
    assign cx[3] = r_x2;  assign cy[3] = r_y2;

    for (genvar c = 0; c < 4; c++) begin : g_corner
        logic signed [SW-1:0] tx, ty, w;

        ppr_proj #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_proj (
            .i_clk (i_clk),
            .i_en  (en),
            .i_mat (r_mat),
            .i_x   (cx[c]),
            .i_y   (cy[c]),
            .o_tx  (tx),
            .o_ty  (ty),
            .o_w   (w)
        );

        ppr_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div_x (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (tx),
            .i_den (w),
            .o_quo (mx[c])
        );

        ppr_div #(.FRAC_BITS(FRAC_BITS), .SW(SW)) u_div_y (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (ty),
            .i_den (w),
            .o_quo (my[c])
        );
    end

    // ------------------------------------------------------------------
    // bounding box and output register
    // ------------------------------------------------------------------
    ppr_box u_box (
        .i_clk  (i_clk),
        .i_en   (en),
        .i_ctl  (r_ctl[CTL_DLY]),
        .i_xs   (mx),
        .i_ys   (my),
        .o_item (o_item)
    );

endmodule

[rtl/core/ppr_checker.sv]
// ----------------------------------------------------------------------------
// ppr_checker
// port-level checks of the mapper, bound to the top level
// ----------------------------------------------------------------------------
module ppr_checker (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               o_valid,
    input  logic               i_stall,
    input  logic               o_stall,
    input  ppr_pkg::t_out_item o_item
);

    // input is held exactly when the output is held
    a_stall_link: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow output hold");

    // a held result stays put
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_item))
        else $error("held result changed");

    // nothing comes out right after reset
    a_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

    // box extents are never negative
    a_extent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_item.out_width[31] && !o_item.out_height[31])
        else $error("negative box extent");

endmodule

bind projective_point_rect_map_core ppr_checker u_ppr_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_stall (o_stall),
    .o_item  (o_item)
);
